@@ design/nnm_pkg.sv @@
// Shared types and constants for the nearest-neighbor coordinate mapper.
// No dependencies; imported by every module of the block.
`default_nettype none
package nnm_pkg;

  localparam int CoordW   = 16;           // coordinate and extent width
  localparam int NumW     = 2 * CoordW + 1; // (2*dest+1)*src needs 33 bits
  localparam int RemW     = CoordW + 1;     // partial remainder, below 2*dest_extent
  localparam int DivSteps = CoordW;         // one quotient bit per cell
  localparam int CfgIdxW  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEST_EXTENT = 2'd0,
    REG_SRC_EXTENT  = 2'd1
  } cfg_reg_e;

  // Payload that travels down the divider chain.
  typedef struct packed {
    logic [RemW-1:0]   rem;     // running remainder
    logic [CoordW-1:0] num_lo;  // numerator bits not yet shifted in, MSB next
    logic [CoordW-1:0] quo;     // quotient bits found so far
    logic              zero;    // disabled axis or coordinate out of range
  } nnm_cell_t;

endpackage : nnm_pkg
`default_nettype wire

@@ design/nearest_neighbor_coordinate_map_core.sv @@
// Top level of the nearest-neighbor coordinate mapper: config registers,
// entry cell and a chain of division cells. Depends on nnm_pkg, nnm_front, nnm_div_cell.
//
//   channel | signals                               | width
//   in      | in_valid_i  in_ready_o  dest_coord_i  | 16
//   out     | out_valid_o out_ready_i src_coord_o   | 16
//   cfg     | cfg_we_i    cfg_idx_i   cfg_data_i    | 2 / 16
//
// One item per cycle sustained while out is not stalled; the path is the numerator multiply
// register plus 16 division cells, one quotient bit per cell.
// Reset clears all cell valid bits and both extents to zero.
// A stall on out holds the run of full cells nearest out at once through the ready chain;
// empty cells keep accepting, so full cells behind them still move up.
`default_nettype none
module nearest_neighbor_coordinate_map_core import nnm_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CoordW-1:0]  cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [CoordW-1:0]  dest_coord_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [CoordW-1:0]       src_coord_o
);

  logic [CoordW-1:0] dest_ext_q, src_ext_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_ext_q <= '0;
      src_ext_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEST_EXTENT: dest_ext_q <= cfg_data_i;
        REG_SRC_EXTENT:  src_ext_q  <= cfg_data_i;
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  logic      valid_w [DivSteps+1];
  logic      ready_w [DivSteps+1];
  nnm_cell_t data_w  [DivSteps+1];

  nnm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dest_extent_i (dest_ext_q),
    .src_extent_i  (src_ext_q),
    .up_valid_i    (in_valid_i),
    .up_ready_o    (in_ready_o),
    .dest_coord_i  (dest_coord_i),
    .down_valid_o  (valid_w[0]),
    .down_ready_i  (ready_w[0]),
    .down_data_o   (data_w[0])
  );

  for (genvar g = 0; g < DivSteps; g++) begin : g_cell
    nnm_div_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .dest_extent_i (dest_ext_q),
      .up_valid_i    (valid_w[g]),
      .up_ready_o    (ready_w[g]),
      .up_data_i     (data_w[g]),
      .down_valid_o  (valid_w[g+1]),
      .down_ready_i  (ready_w[g+1]),
      .down_data_o   (data_w[g+1])
    );
  end

  nnm_cell_t last;
  assign last              = data_w[DivSteps];
  assign out_valid_o       = valid_w[DivSteps];
  assign ready_w[DivSteps] = out_ready_i;

  // Zero for invalid requests, otherwise clamp the quotient below src_extent.
  always_comb begin
    priority if (last.zero) begin
      src_coord_o = '0;
    end else if (last.quo >= src_ext_q) begin
      src_coord_o = src_ext_q - CoordW'(1);
    end else begin
      src_coord_o = last.quo;
    end
  end

  a_disabled_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (dest_ext_q == '0 || src_ext_q == '0)) |-> (src_coord_o == '0))
    else $error("nonzero result on a disabled axis");

  a_below_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && src_ext_q != '0) |-> (src_coord_o < src_ext_q))
    else $error("result at or past src_extent");

  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input blocked without an output stall");

endmodule : nearest_neighbor_coordinate_map_core
`default_nettype wire

@@ design/nnm_front.sv @@
// Entry cell: forms the exact numerator and the zero-result flag.
// Depends on nnm_pkg.
`default_nettype none
module nnm_front import nnm_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [CoordW-1:0] dest_extent_i,
  input  wire logic [CoordW-1:0] src_extent_i,
  input  wire logic              up_valid_i,
  output logic                   up_ready_o,
  input  wire logic [CoordW-1:0] dest_coord_i,
  output logic                   down_valid_o,
  input  wire logic              down_ready_i,
  output nnm_cell_t              down_data_o
);

  logic            valid_q;
  nnm_cell_t       data_q, data_d;
  logic [NumW-1:0] num;

  assign num = NumW'({dest_coord_i, 1'b1}) * NumW'(src_extent_i);

  always_comb begin
    data_d.rem    = num[NumW-1:CoordW];
    data_d.num_lo = num[CoordW-1:0];
    data_d.quo    = '0;
    data_d.zero   = (dest_extent_i == '0) || (src_extent_i == '0) ||
                    (dest_coord_i >= dest_extent_i);
  end

  assign up_ready_o = !valid_q || down_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      data_q <= data_d;
    end
  end

  assign down_valid_o = valid_q;
  assign down_data_o  = data_q;

endmodule : nnm_front
`default_nettype wire

@@ design/nnm_div_cell.sv @@
// One restoring-division cell: shifts in a numerator bit, finds one quotient bit.
// Depends on nnm_pkg.
`default_nettype none
module nnm_div_cell import nnm_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [CoordW-1:0] dest_extent_i,
  input  wire logic              up_valid_i,
  output logic                   up_ready_o,
  input  wire nnm_cell_t         up_data_i,
  output logic                   down_valid_o,
  input  wire logic              down_ready_i,
  output nnm_cell_t              down_data_o
);

  logic            valid_q;
  nnm_cell_t       data_q, data_d;
  logic [RemW:0]   trial;
  logic [RemW:0]   den;
  logic [RemW:0]   diff;
  logic            fits;

  assign den   = {1'b0, dest_extent_i, 1'b0};
  assign trial = {up_data_i.rem, up_data_i.num_lo[CoordW-1]};
  assign diff  = trial - den;
  assign fits  = (trial >= den);

  always_comb begin
    data_d.rem    = fits ? diff[RemW-1:0] : trial[RemW-1:0];
    data_d.num_lo = {up_data_i.num_lo[CoordW-2:0], 1'b0};
    data_d.quo    = {up_data_i.quo[CoordW-2:0], fits};
    data_d.zero   = up_data_i.zero;
  end

  assign up_ready_o = !valid_q || down_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      data_q <= data_d;
    end
  end

  assign down_valid_o = valid_q;
  assign down_data_o  = data_q;

endmodule : nnm_div_cell
`default_nettype wire

@@ sim/tb_nearest_neighbor_coordinate_map_core.sv @@
// Testbench for nearest_neighbor_coordinate_map_core: drives destination coordinates,
// predicts the sampled source coordinate for each and checks results in order.
// Depends on nnm_pkg and the core RTL only.
`timescale 1ns / 100ps
module tb_nearest_neighbor_coordinate_map_core;
  import nnm_pkg::*;

  // Register indexes with no register behind them; writes there must not land.
  localparam logic [CfgIdxW-1:0] CfgIdxSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareB = 2'd3;
  localparam int IdlePct = 21;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CoordW-1:0] cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [CoordW-1:0] dest_coord_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [CoordW-1:0] src_coord_o;

  // Local copy of the extent registers
  logic [CoordW-1:0] dest_ext = '0;
  logic [CoordW-1:0] src_ext = '0;

  logic [CoordW-1:0] pending_coords[$];
  logic [CoordW-1:0] expected_src[$];
  logic [CoordW-1:0] want_src;
  bit                calm = 1'b0;
  int                errors = 0;
  int                coords_mapped = 0;
  int                results_seen = 0;
  int                settings_used = 0;

  nearest_neighbor_coordinate_map_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .dest_coord_i(dest_coord_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .src_coord_o (src_coord_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb_nearest_neighbor_coordinate_map_core: errors");
    $finish;
  end

  function automatic bit take_gap();
    return !calm && ($urandom_range(99) < IdlePct);
  endfunction

  // floor(((2*d+1)*src)/(2*dest)), clamped to src-1, formed at 34 bits; zero if disabled or d out of range
  function automatic logic [CoordW-1:0] scale_coord(input logic [CoordW-1:0] d);
    logic [NumW:0] num;
    logic [NumW:0] den;
    logic [NumW:0] quo;
    if (dest_ext == '0 || src_ext == '0 || d >= dest_ext) return '0;
    num = {{(NumW - CoordW){1'b0}}, d, 1'b1} * src_ext;
    den = {{(NumW - CoordW){1'b0}}, dest_ext, 1'b0};
    quo = num / den;
    if (quo >= src_ext) quo = {{(NumW + 1 - CoordW){1'b0}}, src_ext - 1'b1};
    return quo[CoordW-1:0];
  endfunction

  // Driver: hold the item until accepted, then advance or go idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      dest_coord_i <= '0;
    end else if (!in_valid_i || in_ready_o) begin
      if (pending_coords.size() != 0 && !take_gap()) begin
        in_valid_i <= 1'b1;
        dest_coord_i <= pending_coords.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !take_gap();
    end
  end

  // Monitor: predict on input acceptance, compare on output acceptance.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_src.push_back(scale_coord(dest_coord_i));
        coords_mapped++;
      end
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_src.size() == 0) begin
          $error("src_coord: no result expected, got %0d", src_coord_o);
          errors++;
        end else begin
          want_src = expected_src.pop_front();
          if (src_coord_o !== want_src) begin
            $error("src_coord: expected %0d, got %0d", want_src, src_coord_o);
            errors++;
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CoordW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_DEST_EXTENT) dest_ext = val;
    else if (idx == REG_SRC_EXTENT) src_ext = val;
  endtask

  task automatic set_extents(input logic [CoordW-1:0] dext, input logic [CoordW-1:0] sext);
    write_reg(REG_DEST_EXTENT, dext);
    write_reg(REG_SRC_EXTENT, sext);
    settings_used++;
  endtask

  // Wait until every item went in and every result came back.
  task automatic drain();
    do @(negedge clk_i);
    while (pending_coords.size() != 0 || in_valid_i || expected_src.size() != 0);
  endtask

  function automatic logic [CoordW-1:0] pick_extent();
    case ($urandom_range(5))
      0: return 16'hFFFF;
      1: return CoordW'($urandom_range(16, 1));
      2: return CoordW'($urandom_range(1024, 1));
      3: return CoordW'($urandom_range(3));
      default: return CoordW'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // Mostly in-range coordinates, some at the edge, some anywhere.
  function automatic logic [CoordW-1:0] pick_coord();
    int unsigned r;
    r = $urandom_range(99);
    if (dest_ext == '0 || r < 10) return CoordW'($urandom_range(16'hFFFF));
    if (r < 15) return dest_ext - 1'b1;
    if (r < 18) return dest_ext;
    return CoordW'($urandom_range(dest_ext - 1));
  endfunction

  initial begin
    int n_items;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Extents still zero after reset: everything maps to zero.
    pending_coords = '{16'd0, 16'hFFFF, 16'd1};
    drain();
    write_reg(CfgIdxSpareA, 16'h1234);
    write_reg(CfgIdxSpareB, 16'hFFFF);
    pending_coords.push_back(16'd5);
    drain();

    // Downscale by two, plus out-of-range coordinates
    set_extents(16'd4, 16'd8);
    pending_coords = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'hFFFF};
    drain();
    write_reg(CfgIdxSpareA, 16'd0);
    write_reg(CfgIdxSpareB, 16'd0);
    pending_coords.push_back(16'd3);
    drain();

    set_extents(16'hFFFF, 16'hFFFF);
    pending_coords = '{16'd0, 16'h7FFF, 16'hFFFE, 16'hFFFF};
    drain();
    set_extents(16'hFFFF, 16'd1);
    pending_coords = '{16'd0, 16'hFFFE};
    drain();
    set_extents(16'd1, 16'hFFFF);
    pending_coords = '{16'd0, 16'd1};
    drain();
    // Disabled axis on either side
    set_extents(16'd0, 16'd100);
    pending_coords.push_back(16'd0);
    drain();
    set_extents(16'd100, 16'd0);
    pending_coords.push_back(16'd50);
    drain();
    set_extents(16'd3, 16'd2);
    pending_coords = '{16'd0, 16'd1, 16'd2};
    drain();

    for (int ph = 0; ph < 11; ph++) begin
      if (ph == 0) set_extents(16'hFFFF, 16'hFFFF);
      else if (ph == 1) set_extents(16'hFFFF, 16'd1);
      else set_extents(pick_extent(), pick_extent());
      if ($urandom_range(3) == 0) begin
        write_reg(CfgIdxW'(CfgIdxSpareA + $urandom_range(1)), CoordW'($urandom()));
      end
      calm = (ph == 4);
      n_items = $urandom_range(115, 95);
      repeat (n_items) pending_coords.push_back(pick_coord());
      drain();
    end
    calm = 1'b0;

    // Catch any stray result after the pipeline has emptied.
    repeat (40) @(posedge clk_i);
    $display("mapped %0d coordinates under %0d extent settings, %0d results checked",
             coords_mapped, settings_used, results_seen);
    if (errors == 0) begin
      $display("tb_nearest_neighbor_coordinate_map_core: clean");
    end else begin
      $display("tb_nearest_neighbor_coordinate_map_core: errors");
    end
    $finish;
  end

endmodule
